// ----- rtl/ofr_pkg.sv -----
// ----------------------------------------------------------------------------
// ofr_pkg
// Shared constants, types and the 5x7 font for the OLED text frame store.
// ----------------------------------------------------------------------------
package ofr_pkg;

	localparam int TEXT_COLUMNS = 21;
	localparam int FRAME_BYTES  = 1024;
	localparam int CHUNK_BYTES  = 16;

	localparam int PAGES       = 8;
	localparam int PAGE_COLS   = 128;
	localparam int GLYPH_COLS  = 5;
	localparam int CELL_PITCH  = 6;
	localparam int CMD_BYTES   = 3;
	localparam int CHUNK_IDX_W = 6;

	localparam int ADDR_W = $clog2(FRAME_BYTES);
	localparam int PUT_W  = $clog2(PAGES * PAGE_COLS);
	localparam int POS_W  = $clog2((1 << CHUNK_IDX_W) * CHUNK_BYTES);
	localparam int RD_W   = ((POS_W > ADDR_W) ? POS_W : ADDR_W) + 1;
	localparam int CNT_W  = (ADDR_W > 6) ? ADDR_W : 6;

	localparam logic [2:0] OP_CLEAR   = 3'd0;
	localparam logic [2:0] OP_PUT     = 3'd1;
	localparam logic [2:0] OP_START   = 3'd2;
	localparam logic [2:0] OP_STEP    = 3'd3;
	localparam logic [2:0] OP_PRESENT = 3'd4;
	localparam logic [2:0] OP_FAIL    = 3'd5;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_CMD    = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;

	localparam logic [7:0] PAGE_CMD   = 8'hB0;
	localparam logic [7:0] COL_HI_CMD = 8'h10;

	typedef enum logic [1:0] {
		ACT_STATUS,
		ACT_CLEAR,
		ACT_PUT,
		ACT_STEP
	} act_t;

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_STATUS = 6'b000100,
		ST_CLEAR  = 6'b001000,
		ST_PUT    = 6'b010000,
		ST_STEP   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_wr;
		logic put_wr;
		logic step_run;
		logic emit_status;
	} ofr_cmd_t;

	typedef struct packed {
		act_t act;
		logic clr_last;
		logic put_last;
		logic step_last;
	} ofr_stat_t;

	// One pixel column of the glyph for a character code.
	function automatic logic [7:0] font_column(input logic [7:0] code, input logic [2:0] col);
		logic [7:0]  c;
		logic [39:0] g;
		logic [7:0]  r;
		c = code;
		if (c >= 8'h61 && c <= 8'h7A) begin
			c = c - 8'h20;
		end
		case (c)
			8'h30: g = 40'h3E_51_49_45_3E;
			8'h31: g = 40'h00_42_7F_40_00;
			8'h32: g = 40'h42_61_51_49_46;
			8'h33: g = 40'h21_41_45_4B_31;
			8'h34: g = 40'h18_14_12_7F_10;
			8'h35: g = 40'h27_45_45_45_39;
			8'h36: g = 40'h3C_4A_49_49_30;
			8'h37: g = 40'h01_71_09_05_03;
			8'h38: g = 40'h36_49_49_49_36;
			8'h39: g = 40'h06_49_49_29_1E;
			8'h41: g = 40'h7E_11_11_11_7E;
			8'h42: g = 40'h7F_49_49_49_36;
			8'h43: g = 40'h3E_41_41_41_22;
			8'h44: g = 40'h7F_41_41_22_1C;
			8'h45: g = 40'h7F_49_49_49_41;
			8'h46: g = 40'h7F_09_09_09_01;
			8'h47: g = 40'h3E_41_49_49_7A;
			8'h48: g = 40'h7F_08_08_08_7F;
			8'h49: g = 40'h00_41_7F_41_00;
			8'h4A: g = 40'h20_40_41_3F_01;
			8'h4B: g = 40'h7F_08_14_22_41;
			8'h4C: g = 40'h7F_40_40_40_40;
			8'h4D: g = 40'h7F_02_0C_02_7F;
			8'h4E: g = 40'h7F_04_08_10_7F;
			8'h4F: g = 40'h3E_41_41_41_3E;
			8'h50: g = 40'h7F_09_09_09_06;
			8'h51: g = 40'h3E_41_51_21_5E;
			8'h52: g = 40'h7F_09_19_29_46;
			8'h53: g = 40'h46_49_49_49_31;
			8'h54: g = 40'h01_01_7F_01_01;
			8'h55: g = 40'h3F_40_40_40_3F;
			8'h56: g = 40'h1F_20_40_20_1F;
			8'h57: g = 40'h3F_40_38_40_3F;
			8'h58: g = 40'h63_14_08_14_63;
			8'h59: g = 40'h07_08_70_08_07;
			8'h5A: g = 40'h61_51_49_45_43;
			8'h20: g = 40'h00_00_00_00_00;
			8'h2D: g = 40'h08_08_08_08_08;
			8'h5F: g = 40'h40_40_40_40_40;
			8'h2B: g = 40'h08_08_3E_08_08;
			8'h2E: g = 40'h00_00_60_00_00;
			8'h3A: g = 40'h00_00_36_00_00;
			8'h2F: g = 40'h40_20_10_08_04;
			default: g = 40'h7F_41_41_41_7F;
		endcase
		case (col)
			3'd0: r = g[39:32];
			3'd1: r = g[31:24];
			3'd2: r = g[23:16];
			3'd3: r = g[15:8];
			default: r = g[7:0];
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/ofr_ram.sv -----
// ----------------------------------------------------------------------------
// ofr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ofr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/ofr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ofr_ctrl
// Sequencer: takes a request, then steps the datapath through the clear
// sweep, the glyph write or the refresh burst.
// ----------------------------------------------------------------------------
module ofr_ctrl
	import ofr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ofr_stat_t stat,
	output ofr_cmd_t  cmd,
	output logic      busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				// The frame store is swept to zero once after reset.
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (stat.act)
						ACT_CLEAR: state_d = ST_CLEAR;
						ACT_PUT:   state_d = ST_PUT;
						ACT_STEP:  state_d = ST_STEP;
						default:   state_d = ST_STATUS;
					endcase
				end
			end
			ST_STATUS: begin
				cmd.emit_status = 1'b1;
				state_d         = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_STATUS;
				end
			end
			ST_PUT: begin
				cmd.put_wr = 1'b1;
				if (stat.put_last) begin
					state_d = ST_STATUS;
				end
			end
			ST_STEP: begin
				cmd.step_run = 1'b1;
				if (stat.step_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- rtl/ofr_dp.sv -----
// ----------------------------------------------------------------------------
// ofr_dp
// Datapath: flags, chunk position, step counter, glyph lookup, frame store
// and the result registers.
// ----------------------------------------------------------------------------
module ofr_dp
	import ofr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ofr_cmd_t   cmd,
	output ofr_stat_t  stat,
	input  logic [2:0] operation,
	input  logic [7:0] row,
	input  logic [4:0] text_cell,
	input  logic [7:0] char_code,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	output logic       result_valid,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       is_last,
	output logic       busy_res,
	output logic       present
);

	logic [6:0]             col_off_q;
	logic                   busy_flag_q;
	logic                   present_q;
	logic [CHUNK_IDX_W-1:0] chunk_q;
	logic [POS_W-1:0]       pos_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [2:0]             row_q;
	logic [4:0]             cell_q;
	logic [7:0]             code_q;

	logic                   res_valid_q;
	logic [1:0]             kind_q;
	logic [7:0]             byte_q;
	logic                   last_q;
	logic                   busy_res_q;
	logic                   present_res_q;
	logic                   rd_ok_s1;

	act_t                   act;
	logic [POS_W-1:0]       pos_next;
	logic                   refresh_end;
	logic [PUT_W-1:0]       put_addr;
	logic                   put_in_range;
	logic [RD_W-1:0]        rd_full;
	logic                   rd_ok;
	logic [7:0]             column;
	logic [7:0]             step_byte;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [7:0]             ram_wdata;
	logic [7:0]             ram_rdata;

	// Decide what the offered request will do, from the current flags.
	always_comb begin
		unique case (operation)
			OP_CLEAR: act = busy_flag_q ? ACT_STATUS : ACT_CLEAR;
			OP_PUT: begin
				if (!busy_flag_q && row < 8'(PAGES) && text_cell < 5'(TEXT_COLUMNS)
						&& char_code != 8'd0) begin
					act = ACT_PUT;
				end else begin
					act = ACT_STATUS;
				end
			end
			OP_STEP: act = (present_q && busy_flag_q) ? ACT_STEP : ACT_STATUS;
			default: act = ACT_STATUS;
		endcase
	end

	assign pos_next    = POS_W'(chunk_q) * POS_W'(CHUNK_BYTES);
	assign refresh_end = (RD_W'(pos_next) + RD_W'(CHUNK_BYTES)) >= RD_W'(FRAME_BYTES);

	assign stat.act       = act;
	assign stat.clr_last  = (cnt_q == CNT_W'(FRAME_BYTES - 1));
	assign stat.put_last  = (cnt_q == CNT_W'(GLYPH_COLS - 1));
	assign stat.step_last = (cnt_q == CNT_W'(CMD_BYTES + CHUNK_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_off_q   <= '0;
			busy_flag_q <= 1'b0;
			present_q   <= 1'b0;
			chunk_q     <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				col_off_q <= cfg_data;
			end
			if (cmd.load) begin
				cnt_q <= '0;
				case (operation)
					OP_START: begin
						if (present_q && !busy_flag_q) begin
							busy_flag_q <= 1'b1;
							chunk_q     <= '0;
						end
					end
					OP_STEP: begin
						// Flags move at request time so that every byte of the
						// burst reports the state after the step.
						if (act == ACT_STEP) begin
							chunk_q <= chunk_q + 1'b1;
							if (refresh_end) begin
								busy_flag_q <= 1'b0;
							end
						end
					end
					OP_PRESENT: present_q <= 1'b1;
					OP_FAIL: begin
						present_q   <= 1'b0;
						busy_flag_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end else if (cmd.clr_wr || cmd.put_wr || cmd.step_run) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q  <= row[2:0];
			cell_q <= text_cell;
			code_q <= char_code;
			pos_q  <= pos_next;
		end
	end

	// Glyph write address: page base plus cell offset plus column.
	assign put_addr     = PUT_W'({row_q, 7'd0}) + PUT_W'(cell_q) * PUT_W'(CELL_PITCH)
			+ PUT_W'(cnt_q);
	assign put_in_range = {1'b0, put_addr} < (PUT_W + 1)'(FRAME_BYTES);

	assign ram_we    = cmd.clr_wr || (cmd.put_wr && put_in_range);
	assign ram_waddr = cmd.put_wr ? put_addr[ADDR_W-1:0] : cnt_q[ADDR_W-1:0];
	assign ram_wdata = cmd.put_wr ? font_column(code_q, cnt_q[2:0]) : 8'd0;

	// The read is issued in the cycle before the data byte it feeds, since the RAM read is registered.
	assign rd_full = RD_W'(pos_q) + RD_W'(cnt_q) - RD_W'(CMD_BYTES - 1);
	assign rd_ok   = rd_full < RD_W'(FRAME_BYTES);

	ofr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_full[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	assign column = (8'(pos_q) & 8'h7F) + 8'(col_off_q);

	always_comb begin
		if (cnt_q == CNT_W'(0)) begin
			step_byte = PAGE_CMD | 8'(pos_q >> 7);
		end else if (cnt_q == CNT_W'(1)) begin
			step_byte = {4'd0, column[3:0]};
		end else if (cnt_q == CNT_W'(2)) begin
			step_byte = COL_HI_CMD | {4'd0, column[7:4]};
		end else begin
			step_byte = rd_ok_s1 ? ram_rdata : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit_status || cmd.step_run;
		end
	end

	always_ff @(posedge clk) begin
		rd_ok_s1 <= rd_ok;
		if (cmd.emit_status) begin
			kind_q <= KIND_STATUS;
			byte_q <= 8'd0;
			last_q <= 1'b1;
		end else begin
			kind_q <= (cnt_q < CNT_W'(CMD_BYTES)) ? KIND_CMD : KIND_DATA;
			byte_q <= step_byte;
			last_q <= stat.step_last;
		end
		busy_res_q    <= busy_flag_q;
		present_res_q <= present_q;
	end

	assign result_valid = res_valid_q;
	assign kind         = kind_q;
	assign out_byte     = byte_q;
	assign is_last      = last_q;
	assign busy_res     = busy_res_q;
	assign present      = present_res_q;

endmodule

// ----- rtl/oled_text_framebuffer_refresh.sv -----
// ----------------------------------------------------------------------------
// oled_text_framebuffer_refresh
// Page-organized text frame store for a 128-column display, with 5x7 glyph
// drawing and a chunked refresh that emits command and data bytes.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start, busy            operation, row, text_cell, char_code
//  result    result_valid (strobe)  kind, out_byte, is_last, busy_res, present
//  config    cfg_we                 cfg_data (column offset)
//
// A request is taken when start is high and busy is low.
// Status-only requests hold busy for one cycle; the result appears next cycle.
// A put writes the five glyph columns and a clear zeroes all 1024 bytes,
// one at a time through the single write port of the frame memory.
// A live refresh step shows 19 results on consecutive cycles, one per cycle.
// After reset busy stays high while the memory is zeroed.
// Results are strobed for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module oled_text_framebuffer_refresh
	import ofr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] operation,
	input  logic [7:0] row,
	input  logic [4:0] text_cell,
	input  logic [7:0] char_code,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	output logic       result_valid,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       is_last,
	output logic       busy_res,
	output logic       present
);

	ofr_cmd_t  cmd;
	ofr_stat_t stat;

	ofr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	ofr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.operation   (operation),
		.row         (row),
		.text_cell   (text_cell),
		.char_code   (char_code),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.kind        (kind),
		.out_byte    (out_byte),
		.is_last     (is_last),
		.busy_res    (busy_res),
		.present     (present)
	);

endmodule

// ----- rtl/ofr_checker.sv -----
// ----------------------------------------------------------------------------
// ofr_checker
// Port-level checks for the text frame store, bound to the top level.
// ----------------------------------------------------------------------------
module ofr_checker
	import ofr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_valid,
	input logic [1:0] kind,
	input logic [7:0] out_byte,
	input logic       is_last,
	input logic       present
);

	// Every accepted request raises busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after a request was taken");

	// A status result is a single zero byte that closes its request.
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_STATUS |-> out_byte == 8'd0 && is_last)
		else $error("status result carries a byte or is not last");

	// Command bytes and non-final data bytes are always followed by another command or data byte.
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_last && (kind == KIND_CMD || kind == KIND_DATA)
		|=> result_valid && (kind == KIND_CMD || kind == KIND_DATA))
		else $error("refresh burst broken");

	// Refresh command bytes are only produced while the link is marked present.
	a_cmd_present: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_CMD |-> present)
		else $error("refresh command without link present");

endmodule

bind oled_text_framebuffer_refresh ofr_checker u_ofr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.result_valid(result_valid),
	.kind        (kind),
	.out_byte    (out_byte),
	.is_last     (is_last),
	.present     (present)
);
